// File: design/dfs_maze_carver_core_defines.svh
// ----------------------------------------------------------------------------
// Maze carver assertion macros
// Shorthand for the concurrent checks written at the end of the core.
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_CORE_DEFINES_SVH
`define DFS_MAZE_CARVER_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define DMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dmc_pkg.sv
// ----------------------------------------------------------------------------
// Maze carver package
// Word types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    localparam int CELLS_PER_SIDE_DEF = 10;
    localparam int COORD_W            = 4;
    localparam int DIR_W              = 2;

    localparam logic MODE_START = 1'b0;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [DIR_W-1:0]   direction;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [DIR_W-1:0]   carved_dir;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic               last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE_CHOSEN,
        ST_EVAL_CHOSEN,
        ST_PROBE_SCAN,
        ST_EVAL_SCAN,
        ST_POP,
        ST_POP_LOAD,
        ST_CARVE
    } dmc_state_t;

    typedef struct packed {
        logic load_start;
        logic load_step;
        logic clear_row;
        logic scan_first;
        logic scan_next;
        logic pop;
        logic pop_load;
        logic carve;
    } dmc_cmd_t;

    typedef struct packed {
        logic finished;
        logic open;
        logic probe_last;
        logic stack_empty;
        logic clear_last;
        logic out_free;
    } dmc_stat_t;

endpackage

`default_nettype wire

// File: design/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// Maze carver controller
// Sequences clearing, neighbor probes, stack pops and carving.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl
    import dmc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_valid,
    input  wire logic      step_mode,
    output logic           step_stall,
    input  wire dmc_stat_t stat,
    output dmc_cmd_t       cmd
);

    dmc_state_t state_reg;
    dmc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        step_stall = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_stall = 1'b0;
                if (step_valid)
                begin
                    if (step_mode == MODE_START)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                    else if (!stat.finished)
                    begin
                        cmd.load_step = 1'b1;
                        state_next    = ST_PROBE_CHOSEN;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE_CHOSEN:
            begin
                state_next = ST_EVAL_CHOSEN;
            end
            ST_EVAL_CHOSEN:
            begin
                if (stat.open)
                begin
                    state_next = ST_CARVE;
                end
                else
                begin
                    cmd.scan_first = 1'b1;
                    state_next     = ST_PROBE_SCAN;
                end
            end
            ST_PROBE_SCAN:
            begin
                state_next = ST_EVAL_SCAN;
            end
            ST_EVAL_SCAN:
            begin
                // An open side elsewhere means the chosen side is simply blocked.
                if (stat.open)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.probe_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_PROBE_SCAN;
                end
            end
            ST_POP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_LOAD;
                end
            end
            ST_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_PROBE_CHOSEN;
            end
            ST_CARVE:
            begin
                if (stat.out_free)
                begin
                    cmd.carve  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/dmc_datapath.sv
// ----------------------------------------------------------------------------
// Maze carver datapath
// Visited row memory, backtrack stack memory, position and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath
    import dmc_pkg::*;
#(
    parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  step_word,
    input  wire dmc_cmd_t  cmd,
    output dmc_stat_t      stat,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_word_t      result_word
);

    localparam int CW  = $clog2(CELLS_PER_SIDE);
    localparam int NC  = CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int SAW = $clog2(NC);
    localparam int SDW = $clog2(NC + 1);
    localparam logic [CW-1:0] LAST_COORD = CW'(CELLS_PER_SIDE - 1);

    // One row of visited flags per word; the stack holds {row, column}.
    logic [CELLS_PER_SIDE-1:0] vis_mem [CELLS_PER_SIDE];
    logic [2*CW-1:0]           stk_mem [NC];

    logic [CELLS_PER_SIDE-1:0] vis_rd_reg;
    logic [2*CW-1:0]           stk_rd_reg;

    logic [CW-1:0]    cur_x_reg, cur_x_next;
    logic [CW-1:0]    cur_y_reg, cur_y_next;
    logic [CW-1:0]    row_reg;
    logic [DIR_W-1:0] dir_reg;
    logic [DIR_W-1:0] probe_dir_reg;
    logic [SDW-1:0]   depth_reg;
    logic [SDW-1:0]   count_reg;
    logic             finished_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic [CW-1:0]             nb_x;
    logic [CW-1:0]             nb_y;
    logic                      nb_in;
    logic [CW-1:0]             vis_raddr;
    logic [SDW-1:0]            depth_dec;
    logic [SAW-1:0]            stk_raddr;
    logic [SDW-1:0]            count_inc;
    logic                      all_visited;
    logic [CELLS_PER_SIDE-1:0] start_row;
    logic [CW-1:0]             sx_sat;
    logic [CW-1:0]             sy_sat;

    always_comb
    begin
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        nb_in = 1'b1;
        unique case (probe_dir_reg)
            DIR_UP:
            begin
                nb_in = (cur_y_reg != '0);
                nb_y  = cur_y_reg - CW'(1);
            end
            DIR_DOWN:
            begin
                nb_in = (cur_y_reg < LAST_COORD);
                nb_y  = cur_y_reg + CW'(1);
            end
            DIR_LEFT:
            begin
                nb_in = (cur_x_reg != '0);
                nb_x  = cur_x_reg - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_in = (cur_x_reg < LAST_COORD);
                nb_x  = cur_x_reg + CW'(1);
            end
        endcase
    end

    assign vis_raddr   = nb_in ? nb_y : cur_y_reg;
    assign depth_dec   = depth_reg - SDW'(1);
    assign stk_raddr   = depth_dec[SAW-1:0];
    assign count_inc   = count_reg + SDW'(1);
    assign all_visited = (count_inc == SDW'(NC));

    assign sx_sat = (6'(step_word.start_x) > 6'(CELLS_PER_SIDE - 1)) ?
                    LAST_COORD : CW'(step_word.start_x);
    assign sy_sat = (6'(step_word.start_y) > 6'(CELLS_PER_SIDE - 1)) ?
                    LAST_COORD : CW'(step_word.start_y);

    always_comb
    begin
        start_row            = '0;
        start_row[cur_x_reg] = 1'b1;
    end

    always_comb
    begin
        stat.finished    = finished_reg;
        stat.open        = nb_in && !vis_rd_reg[nb_x];
        stat.probe_last  = (probe_dir_reg == DIR_RIGHT);
        stat.stack_empty = (depth_reg == '0);
        stat.clear_last  = (row_reg == LAST_COORD);
        stat.out_free    = !out_valid_reg || !result_stall;
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        vis_rd_reg <= vis_mem[vis_raddr];
        stk_rd_reg <= stk_mem[stk_raddr];
        if (cmd.clear_row)
        begin
            vis_mem[row_reg] <= (row_reg == cur_y_reg) ? start_row : '0;
        end
        else if (cmd.carve)
        begin
            vis_mem[nb_y] <= vis_rd_reg | (CELLS_PER_SIDE'(1) << nb_x);
        end
        if (cmd.carve && (depth_reg < SDW'(NC)))
        begin
            stk_mem[depth_reg[SAW-1:0]] <= {cur_y_reg, cur_x_reg};
        end
    end

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (cmd.load_start)
        begin
            cur_x_next = sx_sat;
            cur_y_next = sy_sat;
        end
        else if (cmd.pop_load)
        begin
            {cur_y_next, cur_x_next} = stk_rd_reg;
        end
        else if (cmd.carve)
        begin
            cur_x_next = nb_x;
            cur_y_next = nb_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            row_reg       <= '0;
            dir_reg       <= DIR_UP;
            probe_dir_reg <= DIR_UP;
            depth_reg     <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            if (cmd.load_start)
            begin
                row_reg      <= '0;
                depth_reg    <= '0;
                count_reg    <= SDW'(1);
                finished_reg <= 1'b0;
            end
            if (cmd.clear_row)
            begin
                row_reg <= row_reg + CW'(1);
            end
            if (cmd.load_step)
            begin
                dir_reg       <= step_word.direction;
                probe_dir_reg <= step_word.direction;
            end
            if (cmd.scan_first)
            begin
                probe_dir_reg <= DIR_UP;
            end
            if (cmd.scan_next)
            begin
                probe_dir_reg <= probe_dir_reg + DIR_W'(1);
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_dec;
            end
            if (cmd.pop_load)
            begin
                probe_dir_reg <= dir_reg;
            end
            if (cmd.carve)
            begin
                if (depth_reg < SDW'(NC))
                begin
                    depth_reg <= depth_reg + SDW'(1);
                end
                count_reg <= count_inc;
                if (all_visited)
                begin
                    finished_reg <= 1'b1;
                end
            end
            if (cmd.carve)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.carve)
        begin
            out_word_reg.from_x     <= COORD_W'(cur_x_reg);
            out_word_reg.from_y     <= COORD_W'(cur_y_reg);
            out_word_reg.carved_dir <= probe_dir_reg;
            out_word_reg.to_x       <= COORD_W'(nb_x);
            out_word_reg.to_y       <= COORD_W'(nb_y);
            out_word_reg.last       <= all_visited;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

`default_nettype wire

// File: design/dfs_maze_carver_core.sv
// ----------------------------------------------------------------------------
// Depth-first maze carver core
// Recursive backtracker on a square grid, one carved wall per result word.
// ----------------------------------------------------------------------------
// A start word (mode 0) clears the visited map one grid row per cycle and
// places the current cell at the start cell, each coordinate saturated to the
// grid edge; it gives no result. A step word (mode 1) carries a random
// direction. The block probes the chosen neighbor first; if it is on the
// grid and unvisited, the wall is carved, the old cell is pushed on the
// backtrack stack and one result word is produced. Otherwise all four sides
// are probed in turn, up, down, left, right, and if the current cell is
// fully enclosed the stack is popped and the search repeats from the popped
// cell. Every neighbor probe takes a probe state and an evaluation state
// because the visited map is a row-wide memory with a single registered
// read port, and every pop takes a pop state and a load state for the stack
// memory read. A carve also waits for as long as the previous result word
// is held by a stall on the result side. Each pop undoes the push of an
// earlier carve, so a maze has no more pops than carves. The result word
// that visits the last cell has last set; after it, step words are accepted
// and dropped until the next start word. Steps before the first start are
// dropped too. Results sit in an output register, so a new step word is
// taken while the previous result still waits to be read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_maze_carver_core_defines.svh"

module dfs_maze_carver_core
    import dmc_pkg::*;
#(
    parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_valid,
    output logic           step_stall,
    input  wire in_word_t  step_word,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_word_t      result_word
);

    // Commands from the controller and status back from the datapath.
    dmc_cmd_t  cmd;
    dmc_stat_t stat;

    dmc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_mode  (step_word.mode),
        .step_stall (step_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    dmc_datapath #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_word    (step_word),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    // A pop is only issued when the stack holds an entry.
    `DMC_ASSERT_NOW(a_pop_nonempty, clk, rst_n, cmd.pop, !stat.stack_empty, "pop on empty stack")

    // A carve never overwrites a result that has not been taken.
    `DMC_ASSERT_NOW(a_carve_slot, clk, rst_n, cmd.carve, stat.out_free, "carve into full slot")

    // Every carve shows up as a result word in the following cycle.
    `DMC_ASSERT_NEXT(a_carve_result, clk, rst_n, cmd.carve, result_valid, "carve lost its result")

endmodule

`default_nettype wire
